### hw/rtl/ebgc_pkg.sv
// Package of shared types, widths and codes for the exposure-blended gamma curve.
package ebgc_pkg;

    localparam int CODE_W      = 10;
    localparam int XW          = 11;
    localparam int YW          = 10;
    localparam int EW          = 16;
    localparam int BANDW       = 8;
    localparam int REQ_W       = 2;
    localparam int KIDX_W      = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CODE_LEVELS = 1024;
    localparam int BAND_SHIFT  = 5;
    localparam int TH_W        = 20;
    localparam int SPAN_W      = EW + BANDW - BAND_SHIFT;
    localparam int BPROD_W     = YW + EW;
    localparam int SPROD_W     = YW + 1 + XW;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_KNOT    = 2'd0,
        REQ_SET_EXPOSURE = 2'd1,
        REQ_MAP_CODE     = 2'd2
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TH_LOW    = 3'd0,
        CFG_BAND_LOW  = 3'd1,
        CFG_TH_HIGH   = 3'd2,
        CFG_BAND_HIGH = 3'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        RGN_HIGH,
        RGN_HIGH_MID,
        RGN_MID,
        RGN_MID_LOW,
        RGN_LOW
    } region_t;

    typedef enum logic [1:0] {
        SEG_BELOW,
        SEG_ABOVE,
        SEG_INNER,
        SEG_NONE
    } seg_case_t;

    typedef struct packed {
        logic              neg;
        logic [YW-1:0]     y_from;
        logic [CODE_W-1:0] code;
        seg_case_t         seg;
        logic [XW-1:0]     x_a;
        logic [XW-1:0]     x_b;
    } blend_tag_t;

    typedef struct packed {
        logic          neg;
        logic [YW-1:0] y_from;
    } point_tag_t;

    typedef struct packed {
        logic              neg;
        logic [YW-1:0]     y0;
        logic [CODE_W-1:0] code;
    } seg_tag_t;

endpackage

### hw/rtl/ebgc_if.sv
// Channel interfaces: request, response and configuration write.
interface ebgc_req_if;
    logic                           valid;
    logic                           ready;
    logic [ebgc_pkg::REQ_W-1:0]     req_type;
    logic [ebgc_pkg::KIDX_W-1:0]    knot_index;
    logic [ebgc_pkg::XW-1:0]        knot_x;
    logic [ebgc_pkg::YW-1:0]        knot_y_low;
    logic [ebgc_pkg::YW-1:0]        knot_y_mid;
    logic [ebgc_pkg::YW-1:0]        knot_y_high;
    logic [ebgc_pkg::EW-1:0]        exposure_index;
    logic [ebgc_pkg::CODE_W-1:0]    code_in;

    modport source (output valid, req_type, knot_index, knot_x, knot_y_low, knot_y_mid,
                    knot_y_high, exposure_index, code_in, input ready);
    modport sink   (input valid, req_type, knot_index, knot_x, knot_y_low, knot_y_mid,
                    knot_y_high, exposure_index, code_in, output ready);
endinterface

interface ebgc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ebgc_pkg::CODE_W-1:0]    code_echo;
    logic [ebgc_pkg::YW-1:0]        mapped_value;

    modport source (output valid, code_echo, mapped_value, input ready);
    modport sink   (input valid, code_echo, mapped_value, output ready);
endinterface

interface ebgc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ebgc_pkg::CFG_IDX_W-1:0]     index;
    logic [ebgc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/ebgc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a travelling tag.
module ebgc_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 19,
    parameter int QUO_W = 10,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);
    import ebgc_pkg::*;

    localparam int WW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [WW-1:0]    rem_w [QUO_W+1];
    logic [DEN_W-1:0] den_w [QUO_W+1];
    logic [QUO_W-1:0] quo_w [QUO_W+1];
    logic [TAG_W-1:0] tag_w [QUO_W+1];
    logic             vld_w [QUO_W+1];

    logic [WW-1:0]    rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [TAG_W-1:0] tag_reg [QUO_W];
    logic             vld_reg [QUO_W];

    assign rem_w[0] = WW'(num);
    assign den_w[0] = den;
    assign quo_w[0] = '0;
    assign tag_w[0] = tag_in;
    assign vld_w[0] = in_valid;

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - s;
        logic [WW-1:0] trial;
        logic          fits;

        assign trial = WW'(den_w[s]) << BIT;
        assign fits  = rem_w[s] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= fits ? rem_w[s] - trial : rem_w[s];
                den_reg[s] <= den_w[s];
                quo_reg[s] <= quo_w[s] | (QUO_W'(fits) << BIT);
                tag_reg[s] <= tag_w[s];
            end
        end

        assign rem_w[s+1] = rem_reg[s];
        assign den_w[s+1] = den_reg[s];
        assign quo_w[s+1] = quo_reg[s];
        assign tag_w[s+1] = tag_reg[s];
        assign vld_w[s+1] = vld_reg[s];
    end

    assign out_valid = vld_w[QUO_W];
    assign quo       = quo_w[QUO_W];
    assign tag_out   = tag_w[QUO_W];

endmodule

### hw/rtl/exposure_blended_gamma_curve.sv
// A map request reaches its response through 4 front stages, two 10-stage dividers,
// one stage between them and one output register.
// Throughput: one request per cycle; each divider retires one quotient bit per stage.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, asynchronous, active low) clears all valid bits, the four registers and
// the stored exposure; knot storage stays undefined until loaded.
module exposure_blended_gamma_curve #(
    parameter int KNOT_COUNT = 46
) (
    input logic       clk,
    input logic       rst_n,
    ebgc_req_if.sink  req,
    ebgc_rsp_if.source rsp,
    ebgc_cfg_if.sink  cfg
);
    import ebgc_pkg::*;

    localparam int KW = $clog2(KNOT_COUNT);

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances unless the response is held.
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;
    logic accept;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;
    assign accept    = req.valid && advance;

    // ------------------------------------------------------------------
    // Configuration registers and the derived blend band edges.
    // ------------------------------------------------------------------
    logic [EW-1:0]    th_low_reg, th_high_reg;
    logic [BANDW-1:0] band_low_reg, band_high_reg;
    logic [TH_W-1:0]  th1_reg, th3_reg;
    logic [SPAN_W-1:0] span_low_reg, span_high_reg;
    logic [EW+BANDW-1:0] band_prod_low, band_prod_high;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_low_reg    <= '0;
            band_low_reg  <= '0;
            th_high_reg   <= '0;
            band_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TH_LOW:    th_low_reg    <= cfg.data[EW-1:0];
                CFG_BAND_LOW:  band_low_reg  <= cfg.data[BANDW-1:0];
                CFG_TH_HIGH:   th_high_reg   <= cfg.data[EW-1:0];
                CFG_BAND_HIGH: band_high_reg <= cfg.data[BANDW-1:0];
                default: ;
            endcase
        end
    end

    // Band width is threshold * band / 32, floored. Band edges are registered from the
    // configuration registers, in time for a request accepted on the next edge after a write.
    assign band_prod_low  = (EW+BANDW)'(th_low_reg) * (EW+BANDW)'(band_low_reg);
    assign band_prod_high = (EW+BANDW)'(th_high_reg) * (EW+BANDW)'(band_high_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_low_reg  <= '0;
            span_high_reg <= '0;
            th1_reg       <= '0;
            th3_reg       <= '0;
        end
        else
        begin
            span_low_reg  <= band_prod_low[EW+BANDW-1:BAND_SHIFT];
            span_high_reg <= band_prod_high[EW+BANDW-1:BAND_SHIFT];
            th1_reg       <= TH_W'(th_low_reg) + TH_W'(band_prod_low[EW+BANDW-1:BAND_SHIFT]);
            th3_reg       <= TH_W'(th_high_reg)
                           + TH_W'(band_prod_high[EW+BANDW-1:BAND_SHIFT]);
        end
    end

    // ------------------------------------------------------------------
    // Stored exposure and knot storage.
    // The x positions live twice: as a row of cells, each with its own
    // comparator for the segment search, and as a memory for readout.
    // The cells take a load at once; the memories take it from the ld holding
    // registers when the pipeline next advances, so a map request already past
    // entry still reads the knots it was searched against.
    // ------------------------------------------------------------------
    logic [EW-1:0] exposure_reg;
    logic          load_ok;
    logic [KW-1:0] load_idx;

    logic [XW-1:0] x_cell_reg [KNOT_COUNT];
    logic [XW-1:0] x_mem  [KNOT_COUNT];
    logic [YW-1:0] yl_mem [KNOT_COUNT];
    logic [YW-1:0] ym_mem [KNOT_COUNT];
    logic [YW-1:0] yh_mem [KNOT_COUNT];

    logic          ld_vld_reg;
    logic [KW-1:0] ld_idx_reg;
    logic [XW-1:0] ld_x_reg;
    logic [YW-1:0] ld_yl_reg, ld_ym_reg, ld_yh_reg;

    assign load_ok  = accept && (req.req_type == REQ_LOAD_KNOT)
                   && ({1'b0, req.knot_index} < (KIDX_W+1)'(KNOT_COUNT));
    assign load_idx = req.knot_index[KW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_reg <= '0;
        end
        else if (accept && (req.req_type == REQ_SET_EXPOSURE))
        begin
            exposure_reg <= req.exposure_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            x_cell_reg[load_idx] <= req.knot_x;
        end
    end

    // Hold the load until the next advancing edge, then write the memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            ld_vld_reg <= load_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            ld_idx_reg <= load_idx;
            ld_x_reg   <= req.knot_x;
            ld_yl_reg  <= req.knot_y_low;
            ld_ym_reg  <= req.knot_y_mid;
            ld_yh_reg  <= req.knot_y_high;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_vld_reg && advance)
        begin
            x_mem[ld_idx_reg]  <= ld_x_reg;
            yl_mem[ld_idx_reg] <= ld_yl_reg;
            ym_mem[ld_idx_reg] <= ld_ym_reg;
            yh_mem[ld_idx_reg] <= ld_yh_reg;
        end
    end

    // ------------------------------------------------------------------
    // Entry: compare the code against every cell in parallel.
    // ------------------------------------------------------------------
    logic [XW-1:0]         code_x;
    logic [KNOT_COUNT-2:0] hit;
    logic                  below, above;

    assign code_x = XW'(req.code_in);
    assign below  = code_x < x_cell_reg[0];
    assign above  = code_x >= x_cell_reg[KNOT_COUNT-1];

    for (genvar k = 0; k < KNOT_COUNT - 1; k++)
    begin : g_hit
        assign hit[k] = (x_cell_reg[k] <= code_x) && (code_x < x_cell_reg[k+1]);
    end

    logic                  s1_vld_reg;
    logic [CODE_W-1:0]     s1_code_reg;
    logic [KNOT_COUNT-2:0] s1_hit_reg;
    logic                  s1_below_reg, s1_above_reg;
    logic [EW-1:0]         s1_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg <= accept && (req.req_type == REQ_MAP_CODE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_code_reg  <= req.code_in;
            s1_hit_reg   <= hit;
            s1_below_reg <= below;
            s1_above_reg <= above;
            s1_e_reg     <= exposure_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the highest bracketing segment and the blend region.
    // ------------------------------------------------------------------
    logic [KW-1:0]     seg_idx;
    logic              seg_any;
    seg_case_t         seg_next;
    logic [KW-1:0]     addr_a_next, addr_b_next;
    region_t           region_next;
    logic [EW-1:0]     bnum_next;
    logic [SPAN_W-1:0] bden_next;
    logic [TH_W-1:0]   e_ext;

    always_comb
    begin
        seg_idx = '0;
        seg_any = 1'b0;
        for (int k = 0; k < KNOT_COUNT - 1; k++)
        begin
            if (s1_hit_reg[k])
            begin
                seg_idx = KW'(k);
                seg_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (s1_below_reg)
        begin
            seg_next    = SEG_BELOW;
            addr_a_next = '0;
            addr_b_next = '0;
        end
        else if (s1_above_reg)
        begin
            seg_next    = SEG_ABOVE;
            addr_a_next = KW'(KNOT_COUNT - 1);
            addr_b_next = KW'(KNOT_COUNT - 1);
        end
        else if (seg_any)
        begin
            seg_next    = SEG_INNER;
            addr_a_next = seg_idx;
            addr_b_next = seg_idx + KW'(1);
        end
        else
        begin
            seg_next    = SEG_NONE;
            addr_a_next = '0;
            addr_b_next = '0;
        end
    end

    assign e_ext = TH_W'(s1_e_reg);

    always_comb
    begin
        bnum_next = '0;
        bden_next = SPAN_W'(1);
        priority if (s1_e_reg < th_low_reg)
        begin
            region_next = RGN_HIGH;
        end
        else if (e_ext < th1_reg)
        begin
            region_next = RGN_HIGH_MID;
            bnum_next   = s1_e_reg - th_low_reg;
            bden_next   = span_low_reg;
        end
        else if (s1_e_reg < th_high_reg)
        begin
            region_next = RGN_MID;
        end
        else if (e_ext < th3_reg)
        begin
            region_next = RGN_MID_LOW;
            bnum_next   = s1_e_reg - th_high_reg;
            bden_next   = span_high_reg;
        end
        else
        begin
            region_next = RGN_LOW;
        end
    end

    logic              s2_vld_reg;
    logic [CODE_W-1:0] s2_code_reg;
    seg_case_t         s2_seg_reg;
    logic [KW-1:0]     s2_addr_a_reg, s2_addr_b_reg;
    region_t           s2_region_reg;
    logic [EW-1:0]     s2_bnum_reg;
    logic [SPAN_W-1:0] s2_bden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_code_reg   <= s1_code_reg;
            s2_seg_reg    <= seg_next;
            s2_addr_a_reg <= addr_a_next;
            s2_addr_b_reg <= addr_b_next;
            s2_region_reg <= region_next;
            s2_bnum_reg   <= bnum_next;
            s2_bden_reg   <= bden_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: read both bracketing knots from the memories.
    // ------------------------------------------------------------------
    logic              s3_vld_reg;
    logic [CODE_W-1:0] s3_code_reg;
    seg_case_t         s3_seg_reg;
    region_t           s3_region_reg;
    logic [EW-1:0]     s3_bnum_reg;
    logic [SPAN_W-1:0] s3_bden_reg;
    logic [XW-1:0]     s3_xa_reg, s3_xb_reg;
    logic [YW-1:0]     s3_yha_reg, s3_yma_reg, s3_yla_reg;
    logic [YW-1:0]     s3_yhb_reg, s3_ymb_reg, s3_ylb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_code_reg   <= s2_code_reg;
            s3_seg_reg    <= s2_seg_reg;
            s3_region_reg <= s2_region_reg;
            s3_bnum_reg   <= s2_bnum_reg;
            s3_bden_reg   <= s2_bden_reg;
            s3_xa_reg     <= x_mem[s2_addr_a_reg];
            s3_xb_reg     <= x_mem[s2_addr_b_reg];
            s3_yha_reg    <= yh_mem[s2_addr_a_reg];
            s3_yma_reg    <= ym_mem[s2_addr_a_reg];
            s3_yla_reg    <= yl_mem[s2_addr_a_reg];
            s3_yhb_reg    <= yh_mem[s2_addr_b_reg];
            s3_ymb_reg    <= ym_mem[s2_addr_b_reg];
            s3_ylb_reg    <= yl_mem[s2_addr_b_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: choose the curve pair per knot and form |to - from| * num.
    // ------------------------------------------------------------------
    function automatic logic [YW-1:0] curve_from(region_t r, logic [YW-1:0] h,
                                                 logic [YW-1:0] m, logic [YW-1:0] l);
        logic [YW-1:0] y;
        unique case (r)
            RGN_HIGH, RGN_HIGH_MID: y = h;
            RGN_MID, RGN_MID_LOW:   y = m;
            default:                y = l;
        endcase
        return y;
    endfunction

    function automatic logic [YW-1:0] curve_to(region_t r, logic [YW-1:0] h,
                                               logic [YW-1:0] m, logic [YW-1:0] l);
        logic [YW-1:0] y;
        unique case (r)
            RGN_HIGH:     y = h;
            RGN_HIGH_MID: y = m;
            RGN_MID:      y = m;
            default:      y = l;
        endcase
        return y;
    endfunction

    logic [YW-1:0]      from_a, to_a, from_b, to_b;
    logic [YW:0]        bdiff_a, bdiff_b;
    logic [YW-1:0]      bmag_a, bmag_b;
    logic [BPROD_W-1:0] bprod_a, bprod_b;

    assign from_a  = curve_from(s3_region_reg, s3_yha_reg, s3_yma_reg, s3_yla_reg);
    assign to_a    = curve_to(s3_region_reg, s3_yha_reg, s3_yma_reg, s3_yla_reg);
    assign from_b  = curve_from(s3_region_reg, s3_yhb_reg, s3_ymb_reg, s3_ylb_reg);
    assign to_b    = curve_to(s3_region_reg, s3_yhb_reg, s3_ymb_reg, s3_ylb_reg);
    assign bdiff_a = (YW+1)'(to_a) - (YW+1)'(from_a);
    assign bdiff_b = (YW+1)'(to_b) - (YW+1)'(from_b);
    assign bmag_a  = bdiff_a[YW] ? YW'(-bdiff_a) : bdiff_a[YW-1:0];
    assign bmag_b  = bdiff_b[YW] ? YW'(-bdiff_b) : bdiff_b[YW-1:0];
    assign bprod_a = BPROD_W'(bmag_a) * BPROD_W'(s3_bnum_reg);
    assign bprod_b = BPROD_W'(bmag_b) * BPROD_W'(s3_bnum_reg);

    logic               s4_vld_reg;
    logic [BPROD_W-1:0] s4_prod_a_reg, s4_prod_b_reg;
    logic [SPAN_W-1:0]  s4_den_reg;
    blend_tag_t         s4_tag_a_reg;
    point_tag_t         s4_tag_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_prod_a_reg       <= bprod_a;
            s4_prod_b_reg       <= bprod_b;
            s4_den_reg          <= s3_bden_reg;
            s4_tag_a_reg.neg    <= bdiff_a[YW];
            s4_tag_a_reg.y_from <= from_a;
            s4_tag_a_reg.code   <= s3_code_reg;
            s4_tag_a_reg.seg    <= s3_seg_reg;
            s4_tag_a_reg.x_a    <= s3_xa_reg;
            s4_tag_a_reg.x_b    <= s3_xb_reg;
            s4_tag_b_reg.neg    <= bdiff_b[YW];
            s4_tag_b_reg.y_from <= from_b;
        end
    end

    // ------------------------------------------------------------------
    // Blend dividers, one per bracketing knot.
    // ------------------------------------------------------------------
    logic                    div_a_vld, div_b_vld;
    logic [YW-1:0]           div_a_quo, div_b_quo;
    logic [$bits(blend_tag_t)-1:0] div_a_tag;
    logic [$bits(point_tag_t)-1:0] div_b_tag;
    blend_tag_t              ta;
    point_tag_t              tb;

    ebgc_div #(
        .NUM_W (BPROD_W),
        .DEN_W (SPAN_W),
        .QUO_W (YW),
        .TAG_W ($bits(blend_tag_t))
    ) u_blend_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s4_vld_reg),
        .num       (s4_prod_a_reg),
        .den       (s4_den_reg),
        .tag_in    (s4_tag_a_reg),
        .out_valid (div_a_vld),
        .quo       (div_a_quo),
        .tag_out   (div_a_tag)
    );

    ebgc_div #(
        .NUM_W (BPROD_W),
        .DEN_W (SPAN_W),
        .QUO_W (YW),
        .TAG_W ($bits(point_tag_t))
    ) u_blend_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s4_vld_reg),
        .num       (s4_prod_b_reg),
        .den       (s4_den_reg),
        .tag_in    (s4_tag_b_reg),
        .out_valid (div_b_vld),
        .quo       (div_b_quo),
        .tag_out   (div_b_tag)
    );

    assign ta = blend_tag_t'(div_a_tag);
    assign tb = point_tag_t'(div_b_tag);

    // ------------------------------------------------------------------
    // Blended knot values, then the segment end points and the product.
    // ------------------------------------------------------------------
    logic [YW-1:0]      yb_a, yb_b;
    logic [XW-1:0]      sx0, sx1;
    logic [YW-1:0]      sy0;
    logic [YW:0]        sy1;
    logic [YW+1:0]      sdiff;
    logic [YW:0]        smag;
    logic [XW-1:0]      sdx;
    logic               span_ok;
    logic [SPROD_W-1:0] sprod;
    logic [XW-1:0]      sden;

    assign yb_a = ta.neg ? ta.y_from - div_a_quo : ta.y_from + div_a_quo;
    assign yb_b = tb.neg ? tb.y_from - div_b_quo : tb.y_from + div_b_quo;

    always_comb
    begin
        unique case (ta.seg)
            SEG_BELOW:
            begin
                sx0 = '0;
                sy0 = '0;
                sx1 = ta.x_a;
                sy1 = (YW+1)'(yb_a);
            end
            SEG_ABOVE:
            begin
                sx0 = ta.x_a;
                sy0 = yb_a;
                sx1 = XW'(CODE_LEVELS);
                sy1 = (YW+1)'(CODE_LEVELS);
            end
            SEG_INNER:
            begin
                sx0 = ta.x_a;
                sy0 = yb_a;
                sx1 = ta.x_b;
                sy1 = (YW+1)'(yb_b);
            end
            default:
            begin
                // No segment brackets the code: the result is zero.
                sx0 = '0;
                sy0 = '0;
                sx1 = '0;
                sy1 = '0;
            end
        endcase
    end

    assign span_ok = sx1 > sx0;
    assign sdiff   = (YW+2)'(sy1) - (YW+2)'(sy0);
    assign smag    = sdiff[YW+1] ? (YW+1)'(-sdiff) : sdiff[YW:0];
    assign sdx     = XW'(ta.code) - sx0;
    assign sprod   = span_ok ? SPROD_W'(smag) * SPROD_W'(sdx) : '0;
    assign sden    = span_ok ? sx1 - sx0 : XW'(1);

    logic               s5_vld_reg;
    logic [SPROD_W-1:0] s5_prod_reg;
    logic [XW-1:0]      s5_den_reg;
    seg_tag_t           s5_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s5_vld_reg <= div_a_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_prod_reg     <= sprod;
            s5_den_reg      <= sden;
            s5_tag_reg.neg  <= sdiff[YW+1];
            s5_tag_reg.y0   <= sy0;
            s5_tag_reg.code <= ta.code;
        end
    end

    // ------------------------------------------------------------------
    // Segment divider and output register.
    // ------------------------------------------------------------------
    logic                        div_s_vld;
    logic [YW-1:0]               div_s_quo;
    logic [$bits(seg_tag_t)-1:0] div_s_tag;
    seg_tag_t                    tsg;
    logic [YW:0]                 result;

    ebgc_div #(
        .NUM_W (SPROD_W),
        .DEN_W (XW),
        .QUO_W (YW),
        .TAG_W ($bits(seg_tag_t))
    ) u_seg_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s5_vld_reg),
        .num       (s5_prod_reg),
        .den       (s5_den_reg),
        .tag_in    (s5_tag_reg),
        .out_valid (div_s_vld),
        .quo       (div_s_quo),
        .tag_out   (div_s_tag)
    );

    assign tsg    = seg_tag_t'(div_s_tag);
    assign result = tsg.neg ? (YW+1)'(tsg.y0) - (YW+1)'(div_s_quo)
                            : (YW+1)'(tsg.y0) + (YW+1)'(div_s_quo);

    logic [CODE_W-1:0] out_code_reg;
    logic [YW-1:0]     out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= div_s_vld;
        end
    end

    // Drop the top bit: a value of CODE_LEVELS wraps to zero.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg  <= tsg.code;
            out_value_reg <= result[YW-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.code_echo    = out_code_reg;
    assign rsp.mapped_value = out_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_blend_divs_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        div_a_vld == div_b_vld)
        else $error("blend dividers out of step");

    a_map_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == REQ_MAP_CODE)) |=> s1_vld_reg)
        else $error("map request not entered into pipeline");

    a_inner_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && (s2_seg_reg == SEG_INNER)) |-> (s2_addr_b_reg == s2_addr_a_reg + KW'(1)))
        else $error("segment end points not adjacent");

    a_blend_span: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && ((s2_region_reg == RGN_HIGH_MID) || (s2_region_reg == RGN_MID_LOW)))
        |-> ((s2_bden_reg != '0) && (SPAN_W'(s2_bnum_reg) < s2_bden_reg)))
        else $error("blend fraction out of range");

endmodule
